>>> rtl/mgpi_pkg.sv
// Shared types and constants for the most-greater-predecessors index tracker.
// No dependencies.
package mgpi_pkg;

    localparam int VAL_W = 32;
    localparam int OUT_W = 10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

>>> rtl/most_greater_predecessors_index.sv
// Most-greater-predecessors index tracker: value store in a synchronous RAM,
// sequential scan counter and running-best registers. Depends on mgpi_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   input   | in        | in_valid / in_stall  | value[31:0] signed, start_req
//   output  | out       | out_valid/out_stall  | best_index[9:0], best_count[9:0], overflow
//
// An element at position p (p >= 1) is handled in steps: the beat is taken,
// p RAM reads of the earlier elements are issued at one per cycle, the last
// read lands, and then the value is written and the result loaded. Position 0
// and a dropped beat skip the reads. The single RAM read port sets this order.
// Reset clears the list length and the running best; the RAM is not cleared.
// A stalled output holds its beat; the next input beat is still taken and
// scanned, and only the final write-back waits for the output register.
module most_greater_predecessors_index #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [mgpi_pkg::VAL_W-1:0] value,
    input  logic                            start_req,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mgpi_pkg::OUT_W-1:0]      best_index,
    output logic [mgpi_pkg::OUT_W-1:0]      best_count,
    output logic                            overflow
);

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int WIDE_W = (CNT_W > mgpi_pkg::OUT_W) ? CNT_W : mgpi_pkg::OUT_W;

    mgpi_pkg::state_t state_reg, state_next;

    logic signed [mgpi_pkg::VAL_W-1:0] value_reg, value_next;
    logic [ADDR_W-1:0]                 pos_reg, pos_next;
    logic                              drop_reg, drop_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [ADDR_W-1:0]                 best_pos_reg, best_pos_next;
    logic [CNT_W-1:0]                  best_score_reg, best_score_next;
    logic [CNT_W-1:0]                  greater_reg, greater_next;
    logic [ADDR_W-1:0]                 rd_addr_reg, rd_addr_next;
    logic                              rd_pend_reg, rd_pend_next;

    logic                              out_valid_reg, out_valid_next;
    logic [mgpi_pkg::OUT_W-1:0]        best_index_reg, best_index_next;
    logic [mgpi_pkg::OUT_W-1:0]        best_count_reg, best_count_next;
    logic                              overflow_reg, overflow_next;

    logic signed [mgpi_pkg::VAL_W-1:0] mem [MAX_ITEMS];
    logic signed [mgpi_pkg::VAL_W-1:0] rd_data;
    logic                              wr_en;
    logic                              rd_en;

    logic                              in_take;
    logic                              out_free;
    logic                              eff_start;
    logic [CNT_W-1:0]                  base;
    logic                              full;
    logic                              last_addr;
    logic                              new_best;
    logic [WIDE_W-1:0]                 idx_wide;
    logic [WIDE_W-1:0]                 cnt_wide;

    assign in_stall   = (state_reg != mgpi_pkg::ST_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign eff_start  = start_req || (count_reg == '0);
    assign base       = eff_start ? '0 : count_reg;
    assign full       = (base == CNT_W'(MAX_ITEMS));
    assign last_addr  = (rd_addr_reg == pos_reg - ADDR_W'(1));
    assign new_best   = !drop_reg && (greater_reg > best_score_reg);

    // Value store: one write port, one registered read port.
    // Reads only cover positions below the one being written, and the write
    // happens after the scan has finished, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_reg] <= value_reg;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr_reg];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mgpi_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    if (full || (base == '0))
                    begin
                        state_next = mgpi_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = mgpi_pkg::ST_SCAN;
                    end
                end
            end
            mgpi_pkg::ST_SCAN:
            begin
                if (last_addr)
                begin
                    state_next = mgpi_pkg::ST_DRAIN;
                end
            end
            mgpi_pkg::ST_DRAIN:
            begin
                state_next = mgpi_pkg::ST_DONE;
            end
            mgpi_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = mgpi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mgpi_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        value_next      = value_reg;
        pos_next        = pos_reg;
        drop_next       = drop_reg;
        count_next      = count_reg;
        best_pos_next   = best_pos_reg;
        best_score_next = best_score_reg;
        greater_next    = greater_reg;
        rd_addr_next    = rd_addr_reg;
        rd_pend_next    = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        best_index_next = best_index_reg;
        best_count_next = best_count_reg;
        overflow_next   = overflow_reg;
        idx_wide        = WIDE_W'(best_pos_reg);
        cnt_wide        = WIDE_W'(best_score_reg);

        // count the element that landed from the previous read
        if (rd_pend_reg && (rd_data > value_reg))
        begin
            greater_next = greater_reg + CNT_W'(1);
        end

        case (state_reg)
            mgpi_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    value_next   = value;
                    pos_next     = base[ADDR_W-1:0];
                    drop_next    = full;
                    greater_next = '0;
                    rd_addr_next = '0;
                    if (eff_start)
                    begin
                        count_next      = '0;
                        best_pos_next   = '0;
                        best_score_next = '0;
                    end
                end
            end
            mgpi_pkg::ST_SCAN:
            begin
                rd_en        = 1'b1;
                rd_pend_next = 1'b1;
                rd_addr_next = rd_addr_reg + ADDR_W'(1);
            end
            mgpi_pkg::ST_DRAIN:
            begin
            end
            mgpi_pkg::ST_DONE:
            begin
                // hold the result until the output register is free
                if (out_free)
                begin
                    if (new_best)
                    begin
                        best_pos_next   = pos_reg;
                        best_score_next = greater_reg;
                        idx_wide        = WIDE_W'(pos_reg);
                        cnt_wide        = WIDE_W'(greater_reg);
                    end
                    if (!drop_reg)
                    begin
                        wr_en      = 1'b1;
                        count_next = CNT_W'(pos_reg) + CNT_W'(1);
                    end
                    out_valid_next  = 1'b1;
                    best_index_next = idx_wide[mgpi_pkg::OUT_W-1:0];
                    best_count_next = cnt_wide[mgpi_pkg::OUT_W-1:0];
                    overflow_next   = drop_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mgpi_pkg::ST_IDLE;
            count_reg      <= '0;
            best_pos_reg   <= '0;
            best_score_reg <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            best_pos_reg   <= best_pos_next;
            best_score_reg <= best_score_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        pos_reg        <= pos_next;
        drop_reg       <= drop_next;
        greater_reg    <= greater_next;
        rd_addr_reg    <= rd_addr_next;
        best_index_reg <= best_index_next;
        best_count_reg <= best_count_next;
        overflow_reg   <= overflow_next;
    end

    assign out_valid  = out_valid_reg;
    assign best_index = best_index_reg;
    assign best_count = best_count_reg;
    assign overflow   = overflow_reg;

    // A new result beat only ever comes from the write-back state.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == mgpi_pkg::ST_DONE))
        else $error("result beat raised outside write-back");

    // The scan never reads at or beyond the position being written.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mgpi_pkg::ST_SCAN) |-> (rd_addr_reg < pos_reg))
        else $error("scan address past current position");

    // The best position always lies inside the current list.
    a_best_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CNT_W'(best_pos_reg) < count_reg))
        else $error("best position outside list");

    // A score can never exceed the number of earlier elements.
    a_score_bound: assert property (@(posedge clk) disable iff (!rst_n)
        best_score_reg <= count_reg)
        else $error("best score above list length");

endmodule
